// ===== rtl/zone_first_fit_allocator_top_defines.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef ZONE_FIRST_FIT_ALLOCATOR_TOP_DEFINES_SVH
`define ZONE_FIRST_FIT_ALLOCATOR_TOP_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define ZFFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ZFFA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/zffa_pkg.sv =====
package zffa_pkg;

	// Command codes.
	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_FREE  = 2'd1;
	localparam logic [1:0] CMD_CLASS = 2'd2;

	// Result status codes.
	localparam logic [1:0] STAT_DONE     = 2'd0;
	localparam logic [1:0] STAT_NO_SPACE = 2'd1;
	localparam logic [1:0] STAT_NOTICE   = 2'd2;
	localparam logic [1:0] STAT_OVERFLOW = 2'd3;

	// Width of a request in paragraphs, header included.
	localparam int NEED_W = 13;
	// Notices sent at once before the last slot is held back.
	localparam logic [6:0] NOTICE_DIRECT = 7'd62;
	localparam logic [6:0] NOTICE_FULL   = 7'd64;
	// A remainder above this many paragraphs is split off.
	localparam int SPLIT_MIN = 4;

	typedef enum logic [4:0] {
		ST_CLR, ST_IDLE, ST_A1, ST_A2, ST_LOOP, ST_L1, ST_CA0, ST_CHK, ST_CHK2,
		ST_CA1, ST_CA2, ST_CA3, ST_SP0, ST_SP1, ST_SP2, ST_LK1,
		ST_REL0, ST_REL1, ST_REL2, ST_REL3, ST_REL4, ST_REL5, ST_FIN
	} state_t;

endpackage

// ===== rtl/zffa_ram.sv =====
module zffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/zone_first_fit_allocator_top.sv =====
// Channel   Handshake       Payload
// command   start / busy    cmd, request_bytes, has_owner, owner_id, block_addr, cacheable
// result    strobe          status, data_addr, cleared_owner, last
//
// Every block record lives in one RAM word; each list step costs a registered read plus
// the writes it causes.
// After reset a clearing pass over every RAM word runs with busy high.
// Results are held one cycle each on strobe; the receiver cannot stall them.
`include "zone_first_fit_allocator_top_defines.svh"

module zone_first_fit_allocator_top #(
	parameter int HEAP_PARAS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [15:0] request_bytes,
	input  logic        has_owner,
	input  logic [15:0] owner_id,
	input  logic [11:0] block_addr,
	input  logic        cacheable,
	output logic        strobe,
	output logic [1:0]  status,
	output logic [11:0] data_addr,
	output logic [15:0] cleared_owner,
	output logic        last
);

	import zffa_pkg::*;

	localparam int AW    = $clog2(HEAP_PARAS + 1);
	localparam int CW    = (AW > NEED_W) ? AW : NEED_W;
	localparam int SW    = AW + 3;
	localparam int LIMIT = 4 * (HEAP_PARAS + 2);
	localparam logic [AW-1:0] SENT = AW'(HEAP_PARAS);

	typedef struct packed {
		logic [AW-1:0] size;
		logic [AW-1:0] nxt;
		logic [AW-1:0] prv;
		logic          used;
		logic          cache;
		logic          own_v;
		logic [15:0]   own;
	} rec_t;

	localparam int RW = $bits(rec_t);

	state_t state_q, state_d;

	logic [AW-1:0] clr_q, clr_d, rover_q, rover_d, base_q, base_d, cur_q, cur_d;
	logic [AW-1:0] start_q, start_d, pb_q, pb_d, rb_q, rb_d, cidx_q, cidx_d;
	logic [AW-1:0] nnidx_q, nnidx_d;
	logic [SW-1:0] steps_q, steps_d;
	rec_t          brec_q, brec_d, crec_q, crec_d;
	logic          mflag_q, mflag_d, m2_q, m2_d, from_alloc_q, from_alloc_d;
	logic [NEED_W-1:0] need_q, need_d;
	logic          own_v_q, own_v_d, cache_in_q, cache_in_d;
	logic [15:0]   own_q, own_d;
	logic [1:0]    cmd_q, cmd_d;
	logic [6:0]    cnt_q, cnt_d;
	logic          pend_q, pend_d;
	logic [1:0]    pend_st_q, pend_st_d, res_st_q, res_st_d;
	logic [15:0]   pend_own_q, pend_own_d;
	logic [11:0]   res_addr_q, res_addr_d;
	logic          strobe_q, strobe_d, last_q, last_d;
	logic [1:0]    status_q, status_d;
	logic [11:0]   daddr_q, daddr_d;
	logic [15:0]   cowner_q, cowner_d;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	rec_t          wrec, rd;
	logic [RW-1:0] rdata;

	logic [11:0]   hdr12;
	logic          hdr_bad;
	logic [NEED_W-1:0] need_in;
	logic          fits;
	logic [CW-1:0] rest;
	logic [AW-1:0] nb;
	logic [11:0]   base_addr12;

	zffa_ram #(.WIDTH(RW), .DEPTH(HEAP_PARAS + 1)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wrec),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd = rec_t'(rdata);

	// Helpers for the command decode and the fit test.
	assign hdr12       = block_addr - 12'd1;
	assign hdr_bad     = 32'(hdr12) >= HEAP_PARAS;
	assign need_in     = NEED_W'((17'(request_bytes) + 17'd15) >> 4) + NEED_W'(1);
	assign fits        = !rd.used && (CW'(rd.size) >= CW'(need_q));
	assign rest        = CW'(brec_q.size) - CW'(need_q);
	assign nb          = base_q + AW'(need_q);
	assign base_addr12 = 12'(32'(base_q) + 32'd1);

	// State and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			clr_q        <= '0;
			rover_q      <= '0;
			strobe_q     <= 1'b0;
			pend_q       <= 1'b0;
			from_alloc_q <= 1'b0;
			cnt_q        <= '0;
			steps_q      <= '0;
			mflag_q      <= 1'b0;
			m2_q         <= 1'b0;
		end else begin
			state_q      <= state_d;
			clr_q        <= clr_d;
			rover_q      <= rover_d;
			strobe_q     <= strobe_d;
			pend_q       <= pend_d;
			from_alloc_q <= from_alloc_d;
			cnt_q        <= cnt_d;
			steps_q      <= steps_d;
			mflag_q      <= mflag_d;
			m2_q         <= m2_d;
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		base_q     <= base_d;
		cur_q      <= cur_d;
		start_q    <= start_d;
		pb_q       <= pb_d;
		rb_q       <= rb_d;
		cidx_q     <= cidx_d;
		nnidx_q    <= nnidx_d;
		brec_q     <= brec_d;
		crec_q     <= crec_d;
		need_q     <= need_d;
		own_v_q    <= own_v_d;
		own_q      <= own_d;
		cache_in_q <= cache_in_d;
		cmd_q      <= cmd_d;
		pend_st_q  <= pend_st_d;
		pend_own_q <= pend_own_d;
		res_st_q   <= res_st_d;
		res_addr_q <= res_addr_d;
		status_q   <= status_d;
		daddr_q    <= daddr_d;
		cowner_q   <= cowner_d;
		last_q     <= last_d;
	end

	// Sequencer: next state, RAM accesses and register updates.
	always_comb begin
		state_d      = state_q;
		clr_d        = clr_q;
		rover_d      = rover_q;
		base_d       = base_q;
		cur_d        = cur_q;
		start_d      = start_q;
		steps_d      = steps_q;
		pb_d         = pb_q;
		rb_d         = rb_q;
		cidx_d       = cidx_q;
		nnidx_d      = nnidx_q;
		brec_d       = brec_q;
		crec_d       = crec_q;
		mflag_d      = mflag_q;
		m2_d         = m2_q;
		from_alloc_d = from_alloc_q;
		need_d       = need_q;
		own_v_d      = own_v_q;
		own_d        = own_q;
		cache_in_d   = cache_in_q;
		cmd_d        = cmd_q;
		cnt_d        = cnt_q;
		pend_d       = pend_q;
		pend_st_d    = pend_st_q;
		pend_own_d   = pend_own_q;
		res_st_d     = res_st_q;
		res_addr_d   = res_addr_q;
		strobe_d     = 1'b0;
		status_d     = status_q;
		daddr_d      = daddr_q;
		cowner_d     = cowner_q;
		last_d       = last_q;
		we           = 1'b0;
		waddr        = '0;
		wrec         = '0;
		raddr        = '0;

		case (state_q)
			// Build the initial list: one free block and the sentinel.
			ST_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
				if (clr_q == '0) begin
					wrec.size = SENT;
					wrec.nxt  = SENT;
					wrec.prv  = SENT;
				end else if (clr_q == SENT) begin
					wrec.used = 1'b1;
				end
				if (clr_q == SENT) begin
					state_d = ST_IDLE;
				end else begin
					clr_d = clr_q + AW'(1);
				end
			end

			// Take a command and, for a defined command, issue its first read.
			ST_IDLE: begin
				if (start) begin
					need_d     = need_in;
					own_v_d    = has_owner;
					own_d      = has_owner ? owner_id : 16'd0;
					cache_in_d = cacheable;
					cmd_d      = cmd;
					cnt_d      = '0;
					pend_d     = 1'b0;
					steps_d    = '0;
					res_st_d   = STAT_DONE;
					res_addr_d = '0;
					rb_d       = AW'(32'(hdr12));
					case (cmd)
						CMD_ALLOC: begin
							raddr   = rover_q;
							state_d = ST_A1;
						end
						CMD_FREE, CMD_CLASS: begin
							raddr   = AW'(32'(hdr12));
							state_d = hdr_bad ? ST_FIN : ST_LK1;
						end
						default: begin
							state_d = ST_FIN;
						end
					endcase
				end
			end

			// Rover record in hand: look at the block before it.
			ST_A1: begin
				pb_d    = rd.prv;
				raddr   = rd.prv;
				state_d = ST_A2;
			end

			ST_A2: begin
				if (!rd.used) begin
					base_d  = pb_q;
					cur_d   = pb_q;
					start_d = rd.prv;
				end else begin
					base_d  = rover_q;
					cur_d   = rover_q;
					start_d = pb_q;
				end
				state_d = ST_LOOP;
			end

			ST_LOOP: begin
				raddr   = cur_q;
				state_d = ST_L1;
			end

			// One step of the first-fit walk.
			ST_L1: begin
				if (cur_q == start_q || steps_q > SW'(LIMIT)) begin
					res_st_d = STAT_NO_SPACE;
					state_d  = ST_FIN;
				end else begin
					steps_d = steps_q + SW'(1);
					if (rd.used && !rd.cache) begin
						cur_d   = rd.nxt;
						base_d  = rd.nxt;
						state_d = ST_CHK;
					end else if (rd.used) begin
						brec_d  = rd;
						rb_d    = cur_q;
						raddr   = base_q;
						state_d = ST_CA0;
					end else begin
						cur_d   = rd.nxt;
						state_d = ST_CHK;
					end
				end
			end

			ST_CA0: begin
				pb_d         = rd.prv;
				from_alloc_d = 1'b1;
				state_d      = ST_REL0;
			end

			ST_CHK: begin
				raddr   = base_q;
				state_d = ST_CHK2;
			end

			ST_CHK2: begin
				brec_d  = rd;
				state_d = fits ? ST_SP0 : ST_LOOP;
			end

			// After a purge, the walk resumes past the block before the old base.
			ST_CA1: begin
				raddr   = pb_q;
				state_d = ST_CA2;
			end

			ST_CA2: begin
				base_d  = rd.nxt;
				raddr   = rd.nxt;
				state_d = ST_CA3;
			end

			ST_CA3: begin
				cur_d   = rd.nxt;
				brec_d  = rd;
				state_d = fits ? ST_SP0 : ST_LOOP;
			end

			// Split off the remainder, or take the whole block.
			ST_SP0: begin
				res_addr_d = base_addr12;
				if (rest > CW'(SPLIT_MIN)) begin
					we        = 1'b1;
					waddr     = nb;
					wrec.size = AW'(rest);
					wrec.nxt  = brec_q.nxt;
					wrec.prv  = base_q;
					raddr     = brec_q.nxt;
					state_d   = ST_SP1;
				end else begin
					we         = 1'b1;
					waddr      = base_q;
					wrec       = brec_q;
					wrec.used  = 1'b1;
					wrec.cache = 1'b0;
					wrec.own_v = own_v_q;
					wrec.own   = own_q;
					rover_d    = brec_q.nxt;
					state_d    = ST_FIN;
				end
			end

			ST_SP1: begin
				we       = 1'b1;
				waddr    = brec_q.nxt;
				wrec     = rd;
				wrec.prv = nb;
				state_d  = ST_SP2;
			end

			ST_SP2: begin
				we         = 1'b1;
				waddr      = base_q;
				wrec       = brec_q;
				wrec.size  = AW'(need_q);
				wrec.nxt   = nb;
				wrec.used  = 1'b1;
				wrec.cache = 1'b0;
				wrec.own_v = own_v_q;
				wrec.own   = own_q;
				rover_d    = nb;
				state_d    = ST_FIN;
			end

			// Free or class change on a checked header.
			ST_LK1: begin
				if (rd.size == '0 || !rd.used) begin
					state_d = ST_FIN;
				end else if (cmd_q == CMD_FREE) begin
					brec_d       = rd;
					from_alloc_d = 1'b0;
					state_d      = ST_REL0;
				end else begin
					we         = 1'b1;
					waddr      = rb_q;
					wrec       = rd;
					wrec.cache = cache_in_q;
					state_d    = ST_FIN;
				end
			end

			// Release: post the owner notice and fetch the previous block.
			ST_REL0: begin
				if (brec_q.own_v) begin
					if (cnt_q < NOTICE_DIRECT) begin
						strobe_d = 1'b1;
						status_d = STAT_NOTICE;
						daddr_d  = '0;
						cowner_d = brec_q.own;
						last_d   = 1'b0;
					end else if (cnt_q == NOTICE_DIRECT) begin
						pend_d     = 1'b1;
						pend_st_d  = STAT_NOTICE;
						pend_own_d = brec_q.own;
					end else if (cnt_q == NOTICE_DIRECT + 7'd1) begin
						pend_st_d  = STAT_OVERFLOW;
						pend_own_d = '0;
					end
					if (cnt_q < NOTICE_FULL) begin
						cnt_d = cnt_q + 7'd1;
					end
				end
				brec_d.used  = 1'b0;
				brec_d.cache = 1'b0;
				brec_d.own_v = 1'b0;
				brec_d.own   = '0;
				raddr        = brec_q.prv;
				state_d      = ST_REL1;
			end

			// Merge into a free previous block.
			ST_REL1: begin
				if (!rd.used) begin
					crec_d      = rd;
					crec_d.size = rd.size + brec_q.size;
					crec_d.nxt  = brec_q.nxt;
					cidx_d      = brec_q.prv;
					mflag_d     = 1'b1;
					we          = 1'b1;
					waddr       = rb_q;
					wrec        = brec_q;
					wrec.size   = '0;
					if (rover_q == rb_q) begin
						rover_d = brec_q.prv;
					end
				end else begin
					crec_d  = brec_q;
					cidx_d  = rb_q;
					mflag_d = 1'b0;
				end
				state_d = ST_REL2;
			end

			ST_REL2: begin
				raddr   = crec_q.nxt;
				state_d = ST_REL3;
			end

			// Merge a free next block in.
			ST_REL3: begin
				we    = 1'b1;
				waddr = crec_q.nxt;
				wrec  = rd;
				if (mflag_q) begin
					wrec.prv = cidx_q;
				end
				m2_d = 1'b0;
				if (!rd.used) begin
					crec_d.size = crec_q.size + rd.size;
					crec_d.nxt  = rd.nxt;
					wrec.size   = '0;
					nnidx_d     = rd.nxt;
					m2_d        = 1'b1;
					if (rover_q == crec_q.nxt) begin
						rover_d = cidx_q;
					end
				end
				state_d = ST_REL4;
			end

			ST_REL4: begin
				we    = 1'b1;
				waddr = cidx_q;
				wrec  = crec_q;
				if (m2_q) begin
					raddr   = nnidx_q;
					state_d = ST_REL5;
				end else begin
					state_d = from_alloc_q ? ST_CA1 : ST_FIN;
				end
			end

			ST_REL5: begin
				we       = 1'b1;
				waddr    = nnidx_q;
				wrec     = rd;
				wrec.prv = cidx_q;
				state_d  = from_alloc_q ? ST_CA1 : ST_FIN;
			end

			// Held-back notice first, then the final transfer.
			ST_FIN: begin
				strobe_d = 1'b1;
				if (pend_q) begin
					pend_d   = 1'b0;
					status_d = pend_st_q;
					daddr_d  = '0;
					cowner_d = pend_own_q;
					last_d   = 1'b0;
				end else begin
					status_d = res_st_q;
					daddr_d  = (res_st_q == STAT_DONE) ? res_addr_q : 12'd0;
					cowner_d = '0;
					last_d   = 1'b1;
					state_d  = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy          = (state_q != ST_IDLE);
	assign strobe        = strobe_q;
	assign status        = status_q;
	assign data_addr     = daddr_q;
	assign cleared_owner = cowner_q;
	assign last          = last_q;

	`ZFFA_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted command did not raise busy")
	`ZFFA_ASSERT_SAME(a_last_idle, strobe && last, !busy, "final transfer while still busy")
	`ZFFA_ASSERT_SAME(a_notice_not_last, strobe && status == STAT_NOTICE, !last,
		"owner notice marked as final")

endmodule

// ===== tb/sv/tb.sv =====
module tb;
	import zffa_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HEAP = 4096;
	localparam int unsigned SENT = HEAP;
	localparam int unsigned NOTICE_MAX = 63;
	localparam int unsigned SEARCH_CAP = 4 * (HEAP + 2);
	localparam int TAIL_CYCLES = 64;

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] data_addr;
		logic [15:0] cleared_owner;
		logic        last;
	} result_t;

	typedef struct {
		logic [1:0]  cmd;
		logic [15:0] bytes;
		logic        has_owner;
		logic [15:0] owner;
		logic [11:0] addr;
		logic        cache;
		bit          typed;
		logic [1:0]  want_status;
		logic [11:0] want_addr;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  cmd = '0;
	logic [15:0] request_bytes = '0;
	logic        has_owner = 1'b0;
	logic [15:0] owner_id = '0;
	logic [11:0] block_addr = '0;
	logic        cacheable = 1'b0;
	logic        strobe;
	logic [1:0]  status;
	logic [11:0] data_addr;
	logic [15:0] cleared_owner;
	logic        last;

	// Shadow copy of the heap bookkeeping.
	int unsigned blk_size [HEAP + 1];
	int unsigned blk_link_next [HEAP + 1];
	int unsigned blk_link_prev [HEAP + 1];
	bit          blk_used [HEAP + 1];
	bit          blk_cache [HEAP + 1];
	int unsigned blk_tag [HEAP + 1];
	int unsigned search_from;

	result_t     pending_results[$];
	logic [11:0] live_blocks[$];
	int unsigned notices_now;
	result_t     final_now;
	int          mismatches = 0;
	int          items_sent = 0;
	int          results_seen = 0;
	int          notices_seen = 0;
	int          overflows_seen = 0;
	int          no_space_seen = 0;
	bit          quiet_burst = 0;

	zone_first_fit_allocator_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .request_bytes(request_bytes), .has_owner(has_owner),
		.owner_id(owner_id), .block_addr(block_addr), .cacheable(cacheable),
		.strobe(strobe), .status(status), .data_addr(data_addr),
		.cleared_owner(cleared_owner), .last(last)
	);

	always #2 clk = ~clk;

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("[%0t] MISMATCH: %s", $realtime, what);
	endtask

	function automatic void heap_reset();
		for (int i = 0; i <= HEAP; i++) begin
			blk_size[i] = 0;
			blk_link_next[i] = 0;
			blk_link_prev[i] = 0;
			blk_used[i] = 0;
			blk_cache[i] = 0;
			blk_tag[i] = 0;
		end
		blk_size[0] = SENT;
		blk_link_next[0] = SENT;
		blk_link_prev[0] = SENT;
		blk_link_next[SENT] = 0;
		blk_link_prev[SENT] = 0;
		blk_used[SENT] = 1;
		search_from = 0;
	endfunction

	// Owner notices: past the slot limit the last slot turns into an overflow marker.
	function automatic void post_notice(int unsigned own);
		result_t r;
		notices_now++;
		r.data_addr = '0;
		r.last = 1'b0;
		if (notices_now <= NOTICE_MAX) begin
			r.status = STAT_NOTICE;
			r.cleared_owner = own[15:0];
			pending_results.push_back(r);
		end else if (notices_now == NOTICE_MAX + 1) begin
			void'(pending_results.pop_back());
			r.status = STAT_OVERFLOW;
			r.cleared_owner = '0;
			pending_results.push_back(r);
		end
	endfunction

	// Release a block and coalesce it with free neighbors on both sides.
	function automatic void release_block(int unsigned b);
		int unsigned p, n;
		if (blk_tag[b] & 32'h10000)
			post_notice(blk_tag[b] & 32'hFFFF);
		blk_used[b] = 0;
		blk_cache[b] = 0;
		blk_tag[b] = 0;
		p = blk_link_prev[b];
		if (!blk_used[p]) begin
			blk_size[p] += blk_size[b];
			blk_link_next[p] = blk_link_next[b];
			blk_link_prev[blk_link_next[b]] = p;
			if (search_from == b)
				search_from = p;
			blk_size[b] = 0;
			b = p;
		end
		n = blk_link_next[b];
		if (!blk_used[n]) begin
			blk_size[b] += blk_size[n];
			blk_link_next[b] = blk_link_next[n];
			blk_link_prev[blk_link_next[b]] = b;
			if (search_from == n)
				search_from = b;
			blk_size[n] = 0;
		end
	endfunction

	// First-fit search with purging of cache blocks met on the way.
	function automatic bit first_fit(int unsigned bytes, int unsigned tag,
			output int unsigned hdr);
		int unsigned need, base, cur, stop_at, steps, rest, nb;
		need = ((bytes + 15) >> 4) + 1;
		base = search_from;
		steps = 0;
		hdr = 0;
		if (!blk_used[blk_link_prev[base]])
			base = blk_link_prev[base];
		cur = base;
		stop_at = blk_link_prev[base];
		do begin
			if (cur == stop_at || steps++ > SEARCH_CAP)
				return 0;
			if (blk_used[cur]) begin
				if (!blk_cache[cur]) begin
					cur = blk_link_next[cur];
					base = cur;
				end else begin
					base = blk_link_prev[base];
					release_block(cur);
					base = blk_link_next[base];
					cur = blk_link_next[base];
				end
			end else begin
				cur = blk_link_next[cur];
			end
		end while (blk_used[base] || blk_size[base] < need);
		rest = blk_size[base] - need;
		if (rest > SPLIT_MIN) begin
			nb = base + need;
			blk_size[nb] = rest;
			blk_used[nb] = 0;
			blk_cache[nb] = 0;
			blk_tag[nb] = 0;
			blk_link_next[nb] = blk_link_next[base];
			blk_link_prev[nb] = base;
			blk_link_prev[blk_link_next[base]] = nb;
			blk_size[base] = need;
			blk_link_next[base] = nb;
		end
		blk_used[base] = 1;
		blk_cache[base] = 0;
		blk_tag[base] = tag;
		search_from = blk_link_next[base];
		hdr = base;
		return 1;
	endfunction

	function automatic bit find_block(logic [11:0] addr, output int unsigned hdr);
		int unsigned h;
		h = int'(addr - 12'd1);
		hdr = h;
		return !(h >= SENT || blk_size[h] == 0 || !blk_used[h]);
	endfunction

	// Works out every result one accepted command causes.
	function automatic void predict_command(stim_row_t s);
		int unsigned hdr;
		result_t f;
		notices_now = 0;
		f = '0;
		f.last = 1'b1;
		f.status = STAT_DONE;
		case (s.cmd)
			CMD_ALLOC: begin
				if (first_fit(s.bytes, s.has_owner ? (32'h10000 | s.owner) : 0, hdr)) begin
					f.data_addr = 12'(hdr + 1);
					live_blocks.push_back(f.data_addr);
					if (live_blocks.size() > 96)
						live_blocks.delete($urandom_range(0, 95));
				end else begin
					f.status = STAT_NO_SPACE;
				end
			end
			CMD_FREE: begin
				if (find_block(s.addr, hdr))
					release_block(hdr);
			end
			CMD_CLASS: begin
				if (find_block(s.addr, hdr))
					blk_cache[hdr] = s.cache;
			end
			default: ;
		endcase
		pending_results.push_back(f);
		final_now = f;
	endfunction

	// One command transfer: optional idle gap, then hold start until busy is low.
	task automatic issue_command(stim_row_t s);
		int gap;
		gap = quiet_burst ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= s.cmd;
		request_bytes <= s.bytes;
		has_owner <= s.has_owner;
		owner_id <= s.owner;
		block_addr <= s.addr;
		cacheable <= s.cache;
		do @(posedge clk); while (busy);
		items_sent++;
		predict_command(s);
		if (s.typed && (final_now.status != s.want_status ||
				final_now.data_addr != s.want_addr))
			flag_mismatch($sformatf("predictor disagrees with typed row, cmd %0d", s.cmd));
	endtask

	function automatic stim_row_t make_row(logic [1:0] c, logic [15:0] bytes, logic ho,
			logic [15:0] own, logic [11:0] addr, logic ca);
		stim_row_t s;
		s.cmd = c;
		s.bytes = bytes;
		s.has_owner = ho;
		s.owner = own;
		s.addr = addr;
		s.cache = ca;
		s.typed = 0;
		s.want_status = STAT_DONE;
		s.want_addr = '0;
		return s;
	endfunction

	function automatic stim_row_t typed_row(stim_row_t s, logic [1:0] st, logic [11:0] a);
		s.typed = 1;
		s.want_status = st;
		s.want_addr = a;
		return s;
	endfunction

	function automatic logic [11:0] pick_live();
		if (live_blocks.size() == 0)
			return 12'($urandom_range(0, 4095));
		return live_blocks[$urandom_range(0, live_blocks.size() - 1)];
	endfunction

	function automatic stim_row_t random_row();
		int unsigned r;
		logic [15:0] bytes;
		r = $urandom_range(0, 99);
		bytes = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 600));
		if (r < 42)
			return make_row(CMD_ALLOC, bytes, 1'($urandom_range(0, 1)), 16'($urandom),
				12'($urandom), 1'($urandom));
		if (r < 67)
			return make_row(CMD_FREE, 16'($urandom), 1'($urandom), 16'($urandom),
				pick_live(), 1'($urandom));
		if (r < 88)
			return make_row(CMD_CLASS, 16'($urandom), 1'($urandom), 16'($urandom),
				pick_live(), 1'($urandom_range(0, 1)));
		if (r < 96)
			return make_row(2'($urandom_range(1, 2)), 16'($urandom), 1'($urandom),
				16'($urandom), 12'($urandom), 1'($urandom));
		return make_row(2'd3, 16'($urandom), 1'($urandom), 16'($urandom),
			12'($urandom), 1'($urandom));
	endfunction

	// Result checker: every strobe transfer is matched against the oldest expectation.
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && strobe) begin
			got = '{status, data_addr, cleared_owner, last};
			results_seen++;
			if (status == STAT_NOTICE)
				notices_seen++;
			if (status == STAT_OVERFLOW)
				overflows_seen++;
			if (status == STAT_NO_SPACE)
				no_space_seen++;
			if (pending_results.size() == 0) begin
				flag_mismatch($sformatf("unexpected result %p", got));
			end else begin
				want = pending_results.pop_front();
				if (got.status != want.status)
					flag_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
				if (got.data_addr != want.data_addr)
					flag_mismatch($sformatf("data_addr %0d, expected %0d",
						got.data_addr, want.data_addr));
				if (got.cleared_owner != want.cleared_owner)
					flag_mismatch($sformatf("cleared_owner %0h, expected %0h",
						got.cleared_owner, want.cleared_owner));
				if (got.last != want.last)
					flag_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
			end
		end
	end

	// Stimulus.
	initial begin
		stim_row_t directed[$];
		logic [11:0] chain[$];
		int tail;
		heap_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Extremes, bad addresses, undefined command and an explicit owner notice.
		directed.push_back(typed_row(make_row(CMD_ALLOC, 16'd0, 0, 16'h0000, 0, 0),
			STAT_DONE, 12'd1));
		directed.push_back(typed_row(make_row(CMD_ALLOC, 16'hFFFF, 1, 16'hFFFF, 12'hFFF, 1),
			STAT_NO_SPACE, 12'd0));
		directed.push_back(typed_row(make_row(CMD_FREE, 16'hFFFF, 1, 16'hFFFF, 12'd1, 1),
			STAT_DONE, 12'd0));
		directed.push_back(typed_row(make_row(CMD_FREE, 0, 0, 0, 12'd1, 0), STAT_DONE, 12'd0));
		directed.push_back(typed_row(make_row(2'd3, 16'hFFFF, 1, 16'hFFFF, 12'hFFF, 1),
			STAT_DONE, 12'd0));
		directed.push_back(typed_row(make_row(CMD_CLASS, 0, 0, 0, 12'd0, 1), STAT_DONE, 12'd0));
		directed.push_back(make_row(CMD_ALLOC, 16'd16, 1, 16'hFFFF, 0, 0));
		directed.push_back(make_row(CMD_ALLOC, 16'd64, 1, 16'h0000, 0, 0));
		directed.push_back(make_row(CMD_ALLOC, 16'd65, 0, 16'h5A5A, 0, 0));
		directed.push_back(make_row(CMD_ALLOC, 16'd1, 1, 16'hA5A5, 0, 0));
		directed.push_back(make_row(CMD_CLASS, 0, 0, 0, 12'd1, 1));
		directed.push_back(make_row(CMD_CLASS, 0, 0, 0, 12'd3, 1));
		directed.push_back(make_row(CMD_CLASS, 0, 0, 0, 12'd3, 0));
		directed.push_back(make_row(CMD_FREE, 0, 0, 0, 12'd4, 0));
		directed.push_back(make_row(CMD_FREE, 0, 0, 0, 12'd2, 0));
		directed.push_back(make_row(CMD_FREE, 0, 0, 0, 12'd2, 0));
		directed.push_back(make_row(CMD_ALLOC, 16'd60000, 1, 16'h1234, 0, 0));
		directed.push_back(make_row(CMD_ALLOC, 16'hFFFF, 0, 0, 0, 0));
		directed.push_back(make_row(CMD_FREE, 0, 0, 0, 12'hFFF, 0));
		foreach (directed[i])
			issue_command(directed[i]);

		// Hold off until the block has drained everything.
		start <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		// A long chain of owned cache blocks, then a request that never fits,
		// so one search purges them all and overruns the notice slots.
		quiet_burst = 1;
		for (int i = 0; i < 70; i++) begin
			issue_command(make_row(CMD_ALLOC, 16'($urandom_range(0, 15)), 1,
				16'($urandom), 0, 0));
			chain.push_back(final_now.data_addr);
		end
		quiet_burst = 0;
		foreach (chain[i])
			issue_command(make_row(CMD_CLASS, 0, 0, 0, chain[i], 1));
		issue_command(make_row(CMD_ALLOC, 16'hFFFF, 0, 0, 0, 0));

		// Random traffic with stretches of back-to-back commands.
		for (int i = 0; i < 160; i++) begin
			if (i % 40 == 0)
				quiet_burst = $urandom_range(0, 2) == 0;
			issue_command(random_row());
		end
		start <= 1'b0;

		tail = 0;
		while (pending_results.size() != 0 && tail < 2000000) begin
			@(posedge clk);
			tail++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
		$display("Sent %0d commands; checked %0d results (%0d owner notices, %0d overflow",
			items_sent, results_seen, notices_seen, overflows_seen);
		$display("markers, %0d out-of-space answers), %0d mismatches.",
			no_space_seen, mismatches);
		if (mismatches == 0)
			$display("zone_first_fit_allocator_top verification clean");
		else
			$display("zone_first_fit_allocator_top verification failed");
		$finish;
	end

	// Watchdog.
	initial begin
		#1_000_000_000;
		$display("zone_first_fit_allocator_top verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/zffa_pkg.sv
rtl/zffa_ram.sv
rtl/zone_first_fit_allocator_top.sv
tb/sv/tb.sv
